[rtl/csa_pkg.sv]
// ----------------------------------------------------------------------------
// csa_pkg
// Shared codes, field widths and types for the color slot allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

   // Port field widths
   localparam int ACTION_W    = 3;
   localparam int SLOT_IN_W   = 12;
   localparam int COLOR_W     = 32;
   localparam int STATUS_W    = 3;
   localparam int SLOT_OUT_W  = 10;
   localparam int COUNT_OUT_W = 11;

   // Request actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD    = 3'd0,
      ACT_REMOVE = 3'd1,
      ACT_SET    = 3'd2,
      ACT_GET    = 3'd3,
      ACT_FORCE  = 3'd4,
      ACT_FLUSH  = 3'd5
   } action_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STS_OK       = 3'd0,
      STS_FULL     = 3'd1,
      STS_RANGE    = 3'd2,
      STS_SAME     = 3'd3,
      STS_OVERFLOW = 3'd4
   } status_type;

   // Dirty range updates
   typedef enum logic [1:0] {
      RNG_HOLD  = 2'd0,
      RNG_WIDEN = 2'd1,
      RNG_SPAN  = 2'd2,
      RNG_CLEAR = 2'd3
   } range_op_type;

   // Sequencer states
   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } state_type;

endpackage

[rtl/color_slot_allocator.sv]
// ----------------------------------------------------------------------------
// color_slot_allocator
// Slot store of RGBA colors with a free-slot FIFO and a dirty index range.
// ----------------------------------------------------------------------------
//  Channel   Ports                       Handshake
//  request   req_action/slot/rgba        transfer when start & !busy
//  response  rsp_status ... used_count   one cycle, marked by rsp_strobe
//
//  On the accept edge the request issues the color RAM and free FIFO reads;
//  in the EXEC state that follows it compares, writes back and updates pointers.
//  busy is high in EXEC; the response appears in the cycle after EXEC, and
//  a new request may be accepted during that response cycle.
//  Reset clears pointers, counts, the dirty range and the sequencer; the RAMs
//  are not cleared. The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module color_slot_allocator
   import csa_pkg::*;
#(
   parameter int SLOT_CAPACITY    = 1024,
   parameter int FREE_QUEUE_DEPTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [SLOT_IN_W-1:0]   req_slot,
   input  logic [COLOR_W-1:0]     req_rgba,
   output logic                   rsp_strobe,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [SLOT_OUT_W-1:0]  rsp_slot_out,
   output logic [COLOR_W-1:0]     rsp_color_out,
   output logic                   rsp_dirty_valid,
   output logic [SLOT_OUT_W-1:0]  rsp_dirty_low,
   output logic [SLOT_OUT_W-1:0]  rsp_dirty_high,
   output logic [COUNT_OUT_W-1:0] rsp_used_count
);

   localparam int SW = $clog2(SLOT_CAPACITY);
   localparam int CW = $clog2(SLOT_CAPACITY + 1);
   localparam int QW = $clog2(FREE_QUEUE_DEPTH);
   localparam int FW = $clog2(FREE_QUEUE_DEPTH + 1);
   localparam logic [SLOT_IN_W:0] CAP_LIMIT  = (SLOT_IN_W + 1)'(SLOT_CAPACITY);
   localparam logic [CW-1:0]      CAP_COUNT  = CW'(SLOT_CAPACITY);
   localparam logic [FW-1:0]      QUEUE_FULL = FW'(FREE_QUEUE_DEPTH);
   localparam logic [QW-1:0]      QUEUE_LAST = QW'(FREE_QUEUE_DEPTH - 1);

   // Sequencer
   state_type state_ff, state_in;
   logic      accept;

   // Captured request
   logic [ACTION_W-1:0]  action_ff;
   logic [SLOT_IN_W-1:0] slot_ff;
   logic [COLOR_W-1:0]   rgba_ff;

   // Pointers and counts
   logic [QW-1:0] head_ff, head_in;
   logic [QW-1:0] tail_ff, tail_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [CW-1:0] fresh_ff, fresh_in;

   // Response registers
   logic                  strobe_ff, strobe_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [SLOT_OUT_W-1:0] slot_out_ff, slot_out_in;
   logic [COLOR_W-1:0]    color_ff, color_in;

   // Memory ports
   logic               color_we;
   logic [SW-1:0]      color_waddr;
   logic [COLOR_W-1:0] color_rdata;
   logic               queue_we;
   logic [SW-1:0]      queue_rdata;

   // Range tracker
   range_op_type  rng_op;
   logic [SW-1:0] rng_idx;
   logic          rng_valid;
   logic [SW-1:0] rng_low;
   logic [SW-1:0] rng_high;

   logic          slot_ok;
   logic          exec;
   logic [SW-1:0] add_idx;

   assign accept  = start && (state_ff == FSM_IDLE);
   assign exec    = (state_ff == FSM_EXEC);
   assign slot_ok = {1'b0, slot_ff} < CAP_LIMIT;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      busy      = 1'b0;
      strobe_in = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
         end
         FSM_EXEC: begin
            busy      = 1'b1;
            strobe_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Execute the captured request against the read data
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      fresh_in    = fresh_ff;
      status_in   = STS_OK;
      slot_out_in = '0;
      color_in    = '0;
      color_we    = 1'b0;
      color_waddr = slot_ff[SW-1:0];
      queue_we    = 1'b0;
      rng_op      = RNG_HOLD;
      rng_idx     = slot_ff[SW-1:0];
      add_idx     = fresh_ff[SW-1:0];
      if (exec) begin
         case (action_ff)
            ACT_ADD: begin
               if (fill_ff != '0) begin
                  add_idx = queue_rdata;
                  head_in = (head_ff == QUEUE_LAST) ? '0 : head_ff + 1'b1;
                  fill_in = fill_ff - 1'b1;
               end else if (fresh_ff != CAP_COUNT) begin
                  fresh_in = fresh_ff + 1'b1;
               end
               if ((fill_ff != '0) || (fresh_ff != CAP_COUNT)) begin
                  color_we    = 1'b1;
                  color_waddr = add_idx;
                  rng_op      = RNG_WIDEN;
                  rng_idx     = add_idx;
                  slot_out_in = SLOT_OUT_W'(add_idx);
               end else begin
                  status_in = STS_FULL;
               end
            end
            ACT_REMOVE: begin
               slot_out_in = slot_ff[SLOT_OUT_W-1:0];
               if (!slot_ok) begin
                  status_in = STS_RANGE;
               end else if (fill_ff == QUEUE_FULL) begin
                  status_in = STS_OVERFLOW;
               end else begin
                  queue_we = 1'b1;
                  tail_in  = (tail_ff == QUEUE_LAST) ? '0 : tail_ff + 1'b1;
                  fill_in  = fill_ff + 1'b1;
               end
            end
            ACT_SET: begin
               slot_out_in = slot_ff[SLOT_OUT_W-1:0];
               if (!slot_ok) begin
                  status_in = STS_RANGE;
               end else if (color_rdata == rgba_ff) begin
                  status_in = STS_SAME;
               end else begin
                  color_we = 1'b1;
                  rng_op   = RNG_WIDEN;
               end
            end
            ACT_GET: begin
               slot_out_in = slot_ff[SLOT_OUT_W-1:0];
               if (!slot_ok) begin
                  status_in = STS_RANGE;
               end else begin
                  color_in = color_rdata;
               end
            end
            ACT_FORCE: begin
               if (fresh_ff != '0) begin
                  rng_op  = RNG_SPAN;
                  rng_idx = SW'(fresh_ff - 1'b1);
               end else begin
                  rng_op = RNG_CLEAR;
               end
            end
            ACT_FLUSH: begin
               rng_op = RNG_CLEAR;
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_IDLE;
         strobe_ff <= 1'b0;
         head_ff   <= '0;
         tail_ff   <= '0;
         fill_ff   <= '0;
         fresh_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         fill_ff   <= fill_in;
         fresh_ff  <= fresh_in;
      end
   end

   // Capture request on transfer, hold response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         slot_ff   <= req_slot;
         rgba_ff   <= req_rgba;
      end
      if (exec) begin
         status_ff   <= status_in;
         slot_out_ff <= slot_out_in;
         color_ff    <= color_in;
      end
   end

   // Color store
   csa_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (SLOT_CAPACITY)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (color_we),
      .wr_addr (color_waddr),
      .wr_data (rgba_ff),
      .rd_en   (accept),
      .rd_addr (req_slot[SW-1:0]),
      .rd_data (color_rdata)
   );

   // Free slot FIFO
   csa_ram #(
      .WIDTH (SW),
      .DEPTH (FREE_QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (queue_we),
      .wr_addr (tail_ff),
      .wr_data (slot_ff[SW-1:0]),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (queue_rdata)
   );

   // Dirty range
   csa_range #(
      .IDX_W (SW)
   ) u_range (
      .clock (clock),
      .reset (reset),
      .op    (rng_op),
      .idx   (rng_idx),
      .valid (rng_valid),
      .low   (rng_low),
      .high  (rng_high)
   );

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_slot_out    = slot_out_ff;
   assign rsp_color_out   = color_ff;
   assign rsp_dirty_valid = rng_valid;
   assign rsp_dirty_low   = SLOT_OUT_W'(rng_low);
   assign rsp_dirty_high  = SLOT_OUT_W'(rng_high);
   assign rsp_used_count  = COUNT_OUT_W'(fresh_ff);

endmodule

[rtl/csa_ram.sv]
// ----------------------------------------------------------------------------
// csa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/csa_range.sv]
// ----------------------------------------------------------------------------
// csa_range
// Dirty index range tracker: widen to an index, span from zero, or clear.
// ----------------------------------------------------------------------------
module csa_range
   import csa_pkg::*;
#(
   parameter int IDX_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  range_op_type     op,
   input  logic [IDX_W-1:0] idx,
   output logic             valid,
   output logic [IDX_W-1:0] low,
   output logic [IDX_W-1:0] high
);

   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] low_ff, low_in;
   logic [IDX_W-1:0] high_ff, high_in;

   // Compute next range
   always_comb begin
      valid_in = valid_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      case (op)
         RNG_WIDEN: begin
            if (valid_ff) begin
               if (idx < low_ff) begin
                  low_in = idx;
               end
               if (idx > high_ff) begin
                  high_in = idx;
               end
            end else begin
               valid_in = 1'b1;
               low_in   = idx;
               high_in  = idx;
            end
         end
         RNG_SPAN: begin
            valid_in = 1'b1;
            low_in   = '0;
            high_in  = idx;
         end
         RNG_CLEAR: begin
            valid_in = 1'b0;
            low_in   = '0;
            high_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // Hold range registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         low_ff   <= '0;
         high_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
      end
   end

   assign valid = valid_ff;
   assign low   = low_ff;
   assign high  = high_ff;

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for color_slot_allocator. A directed table covers the
// field extremes, every action and the corner cases (out-of-range index,
// unchanged color, repeated remove, force dirty on an empty store, unknown
// actions). Random traffic follows under three sender idle profiles, then a
// mixed tail with the sender idling again. Each response is checked field by
// field against its typed table row or an in-bench prediction of the allocator.
// ----------------------------------------------------------------------------
module tb
   import csa_pkg::*;
();

   localparam int CAP        = 1024;
   localparam int QDEPTH     = 1024;
   localparam int SLOT_AW    = $clog2(CAP);
   localparam int QUEUE_AW   = $clog2(QDEPTH);
   localparam int QUIET_MAX  = 4000;
   localparam int RAND_STAGE = 155;

   // Actions the block treats as no-ops
   localparam logic [ACTION_W-1:0] ACT_RSVD6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_RSVD7 = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [SLOT_OUT_W-1:0]  slot_out;
      logic [COLOR_W-1:0]     color_out;
      logic                   dirty_valid;
      logic [SLOT_OUT_W-1:0]  dirty_low;
      logic [SLOT_OUT_W-1:0]  dirty_high;
      logic [COUNT_OUT_W-1:0] used_count;
   } slot_answer_type;

   typedef struct {
      logic [ACTION_W-1:0]  action;
      logic [SLOT_IN_W-1:0] slot;
      logic [COLOR_W-1:0]   rgba;
      bit                   typed;
      slot_answer_type      answer;
   } slot_req_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [ACTION_W-1:0]    req_action;
   logic [SLOT_IN_W-1:0]   req_slot;
   logic [COLOR_W-1:0]     req_rgba;
   logic                   rsp_strobe;
   logic [STATUS_W-1:0]    rsp_status;
   logic [SLOT_OUT_W-1:0]  rsp_slot_out;
   logic [COLOR_W-1:0]     rsp_color_out;
   logic                   rsp_dirty_valid;
   logic [SLOT_OUT_W-1:0]  rsp_dirty_low;
   logic [SLOT_OUT_W-1:0]  rsp_dirty_high;
   logic [COUNT_OUT_W-1:0] rsp_used_count;

   color_slot_allocator #(
      .SLOT_CAPACITY    (CAP),
      .FREE_QUEUE_DEPTH (QDEPTH)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_slot        (req_slot),
      .req_rgba        (req_rgba),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_color_out   (rsp_color_out),
      .rsp_dirty_valid (rsp_dirty_valid),
      .rsp_dirty_low   (rsp_dirty_low),
      .rsp_dirty_high  (rsp_dirty_high),
      .rsp_used_count  (rsp_used_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the allocator state
   logic [COLOR_W-1:0]    shadow_colors [CAP];
   bit                    slot_written  [CAP];
   logic [SLOT_OUT_W-1:0] shadow_free_q [QDEPTH];
   int                    free_head;
   int                    free_tail;
   int                    free_fill;
   int                    fresh_cnt;
   bit                    rng_valid;
   int                    rng_low;
   int                    rng_high;

   slot_answer_type slot_answers_due[$];
   slot_req_type    directed_rows[$];
   int              fail_count = 0;
   int              idle_pct   = 0;
   int              quiet_cycles = 0;

   // Grow the dirty range to cover one slot
   function automatic void widen_dirty(input int idx);
      if (rng_valid) begin
         if (idx < rng_low) rng_low = idx;
         if (idx > rng_high) rng_high = idx;
      end else begin
         rng_valid = 1'b1;
         rng_low   = idx;
         rng_high  = idx;
      end
   endfunction

   // Apply one request to the shadow state and return the response it earns
   function automatic slot_answer_type predict_slot_op(input logic [ACTION_W-1:0] act,
                                                       input logic [SLOT_IN_W-1:0] sl,
                                                       input logic [COLOR_W-1:0] c);
      slot_answer_type a;
      int idx;
      bit granted;
      a = '0;
      a.status = STS_OK;
      idx = 0;
      granted = 1'b1;
      case (act)
         ACT_ADD: begin
            if (free_fill > 0) begin
               idx = int'(shadow_free_q[free_head[QUEUE_AW-1:0]]);
               free_head = (free_head + 1) % QDEPTH;
               free_fill--;
            end else if (fresh_cnt >= CAP) begin
               a.status = STS_FULL;
               granted = 1'b0;
            end else begin
               idx = fresh_cnt;
               fresh_cnt++;
            end
            if (granted) begin
               shadow_colors[idx[SLOT_AW-1:0]] = c;
               slot_written[idx[SLOT_AW-1:0]]  = 1'b1;
               widen_dirty(idx);
               a.slot_out = SLOT_OUT_W'(idx);
            end
         end
         ACT_REMOVE: begin
            a.slot_out = sl[SLOT_OUT_W-1:0];
            if (sl >= CAP) begin
               a.status = STS_RANGE;
            end else if (free_fill >= QDEPTH) begin
               a.status = STS_OVERFLOW;
            end else begin
               shadow_free_q[free_tail[QUEUE_AW-1:0]] = sl[SLOT_OUT_W-1:0];
               free_tail = (free_tail + 1) % QDEPTH;
               free_fill++;
            end
         end
         ACT_SET: begin
            a.slot_out = sl[SLOT_OUT_W-1:0];
            if (sl >= CAP) begin
               a.status = STS_RANGE;
            end else if (shadow_colors[sl[SLOT_AW-1:0]] == c) begin
               a.status = STS_SAME;
            end else begin
               shadow_colors[sl[SLOT_AW-1:0]] = c;
               widen_dirty(int'(sl));
            end
         end
         ACT_GET: begin
            a.slot_out = sl[SLOT_OUT_W-1:0];
            if (sl >= CAP) a.status = STS_RANGE;
            else a.color_out = shadow_colors[sl[SLOT_AW-1:0]];
         end
         ACT_FORCE: begin
            rng_valid = (fresh_cnt > 0);
            rng_low   = 0;
            rng_high  = (fresh_cnt > 0) ? fresh_cnt - 1 : 0;
         end
         ACT_FLUSH: begin
            rng_valid = 1'b0;
            rng_low   = 0;
            rng_high  = 0;
         end
         default: ;
      endcase
      a.dirty_valid = rng_valid;
      a.dirty_low   = rng_valid ? SLOT_OUT_W'(rng_low) : '0;
      a.dirty_high  = rng_valid ? SLOT_OUT_W'(rng_high) : '0;
      a.used_count  = COUNT_OUT_W'(fresh_cnt);
      return a;
   endfunction

   function automatic slot_req_type build_req(input logic [ACTION_W-1:0] act,
                                              input logic [SLOT_IN_W-1:0] sl,
                                              input logic [COLOR_W-1:0] c);
      slot_req_type r;
      r.action = act;
      r.slot   = sl;
      r.rgba   = c;
      r.typed  = 1'b0;
      r.answer = '0;
      return r;
   endfunction

   // Append a table row; typed rows carry their own expected response
   task automatic add_row(input logic [ACTION_W-1:0] act, input logic [SLOT_IN_W-1:0] sl,
                          input logic [COLOR_W-1:0] c, input bit typed,
                          input status_type st, input int s_out, input logic [31:0] col,
                          input bit dv, input int lo, input int hi, input int used);
      slot_req_type r;
      r = build_req(act, sl, c);
      r.typed = typed;
      r.answer.status      = st;
      r.answer.slot_out    = SLOT_OUT_W'(s_out);
      r.answer.color_out   = col;
      r.answer.dirty_valid = dv;
      r.answer.dirty_low   = SLOT_OUT_W'(lo);
      r.answer.dirty_high  = SLOT_OUT_W'(hi);
      r.answer.used_count  = COUNT_OUT_W'(used);
      directed_rows.push_back(r);
   endtask

   // Pick a written slot, or an out-of-range one at random or if none is found
   function automatic logic [SLOT_IN_W-1:0] pick_readable_slot();
      int s;
      if ($urandom_range(0, 9) == 0) return SLOT_IN_W'($urandom_range(CAP, 4095));
      s = $urandom_range(0, CAP - 1);
      if (!slot_written[s[SLOT_AW-1:0]] && fresh_cnt > 0) s = $urandom_range(0, fresh_cnt - 1);
      if (!slot_written[s[SLOT_AW-1:0]]) return SLOT_IN_W'($urandom_range(CAP, 4095));
      return SLOT_IN_W'(s);
   endfunction

   function automatic slot_req_type next_random_req();
      int pick;
      logic [SLOT_IN_W-1:0] sl;
      logic [COLOR_W-1:0] c;
      pick = $urandom_range(0, 99);
      c = $urandom;
      case ($urandom_range(0, 15))
         0:       c = '0;
         1:       c = '1;
         default: ;
      endcase
      if (pick < 28) begin
         return build_req(ACT_ADD, SLOT_IN_W'($urandom), c);
      end else if (pick < 43) begin
         if ($urandom_range(0, 9) == 0) sl = SLOT_IN_W'($urandom_range(CAP, 4095));
         else if (fresh_cnt > 0 && $urandom_range(0, 1) == 1)
            sl = SLOT_IN_W'($urandom_range(0, fresh_cnt - 1));
         else sl = SLOT_IN_W'($urandom_range(0, CAP - 1));
         return build_req(ACT_REMOVE, sl, c);
      end else if (pick < 63) begin
         sl = pick_readable_slot();
         if (sl < CAP && $urandom_range(0, 3) == 0) c = shadow_colors[sl[SLOT_AW-1:0]];
         return build_req(ACT_SET, sl, c);
      end else if (pick < 83) begin
         return build_req(ACT_GET, pick_readable_slot(), c);
      end else if (pick < 90) begin
         return build_req(ACT_FORCE, SLOT_IN_W'($urandom), c);
      end else if (pick < 96) begin
         return build_req(ACT_FLUSH, SLOT_IN_W'($urandom), c);
      end
      return build_req($urandom_range(0, 1) ? ACT_RSVD6 : ACT_RSVD7, SLOT_IN_W'($urandom), c);
   endfunction

   // Hold off at random, then present one request until it transfers
   task automatic issue(input slot_req_type r);
      slot_answer_type a;
      while ($urandom_range(0, 99) < idle_pct) begin
         start      <= 1'b0;
         req_action <= ACTION_W'($urandom);
         req_slot   <= SLOT_IN_W'($urandom);
         req_rgba   <= $urandom;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_action <= r.action;
      req_slot   <= r.slot;
      req_rgba   <= r.rgba;
      @(posedge clock);
      while (busy) @(posedge clock);
      a = predict_slot_op(r.action, r.slot, r.rgba);
      slot_answers_due.push_back(r.typed ? r.answer : a);
   endtask

   // Stimulus
   initial begin
      reset      <= 1'b1;
      start      <= 1'b0;
      req_action <= '0;
      req_slot   <= '0;
      req_rgba   <= '0;
      free_head = 0;
      free_tail = 0;
      free_fill = 0;
      fresh_cnt = 0;
      rng_valid = 1'b0;
      rng_low   = 0;
      rng_high  = 0;
      foreach (slot_written[i]) slot_written[i] = 1'b0;

      add_row(ACT_FORCE,  0,    32'h0,        1, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_GET,    4095, 32'h0,        1, STS_RANGE, 1023, 32'h0,        0, 0, 0, 0);
      add_row(ACT_REMOVE, 1024, 32'h0,        1, STS_RANGE, 0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_SET,    2053, 32'h12345678, 1, STS_RANGE, 5,    32'h0,        0, 0, 0, 0);
      add_row(ACT_ADD,    0,    32'h00000000, 1, STS_OK,    0,    32'h0,        1, 0, 0, 1);
      add_row(ACT_ADD,    4095, 32'hFFFFFFFF, 1, STS_OK,    1,    32'h0,        1, 0, 1, 2);
      add_row(ACT_GET,    1,    32'h0,        1, STS_OK,    1,    32'hFFFFFFFF, 1, 0, 1, 2);
      add_row(ACT_GET,    0,    32'hFFFFFFFF, 0, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_SET,    1,    32'hFFFFFFFF, 1, STS_SAME,  1,    32'h0,        1, 0, 1, 2);
      add_row(ACT_FLUSH,  0,    32'h0,        1, STS_OK,    0,    32'h0,        0, 0, 0, 2);
      add_row(ACT_SET,    1,    32'hA5A5A5A5, 0, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_REMOVE, 0,    32'h0,        0, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_REMOVE, 1,    32'h0,        0, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_REMOVE, 0,    32'h0,        0, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_ADD,    0,    32'h0F0F0F0F, 0, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_ADD,    0,    32'hF0F0F0F0, 0, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_ADD,    0,    32'h11111111, 0, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_ADD,    0,    32'h5A5A5A5A, 0, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_FORCE,  0,    32'h0,        0, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_RSVD6,  4095, 32'hFFFFFFFF, 0, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_RSVD7,  0,    32'h0,        0, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_GET,    2,    32'h0,        0, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_REMOVE, 1023, 32'h0,        0, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_ADD,    0,    32'h80000001, 0, STS_OK,    0,    32'h0,        0, 0, 0, 0);
      add_row(ACT_SET,    1023, 32'h0,        0, STS_OK,    0,    32'h0,        0, 0, 0, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table and first random stretch with a light sender
      idle_pct = 36;
      foreach (directed_rows[i]) issue(directed_rows[i]);
      repeat (RAND_STAGE) issue(next_random_req());

      // Heavy sender idling
      idle_pct = 77;
      repeat (RAND_STAGE) issue(next_random_req());

      // Back-to-back traffic
      idle_pct = 0;
      repeat (RAND_STAGE) issue(next_random_req());

      // Mixed tail with the sender idling again
      idle_pct = 36;
      repeat (60) issue(next_random_req());

      // Drop start and wait for the last responses
      @(posedge clock);
      start <= 1'b0;
      while (slot_answers_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (fail_count == 0 && slot_answers_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Check each response transfer against the oldest expectation
   always @(posedge clock) begin
      slot_answer_type e;
      if (!reset && rsp_strobe) begin
         if (slot_answers_due.size() == 0) begin
            $error("response with no request pending: status %0d slot %0d",
                   rsp_status, rsp_slot_out);
            fail_count++;
         end else begin
            e = slot_answers_due.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               fail_count++;
            end
            if (rsp_slot_out !== e.slot_out) begin
               $error("slot_out expected %0d actual %0d", e.slot_out, rsp_slot_out);
               fail_count++;
            end
            if (rsp_color_out !== e.color_out) begin
               $error("color_out expected %h actual %h", e.color_out, rsp_color_out);
               fail_count++;
            end
            if (rsp_dirty_valid !== e.dirty_valid) begin
               $error("dirty_valid expected %0d actual %0d", e.dirty_valid, rsp_dirty_valid);
               fail_count++;
            end
            if (rsp_dirty_low !== e.dirty_low) begin
               $error("dirty_low expected %0d actual %0d", e.dirty_low, rsp_dirty_low);
               fail_count++;
            end
            if (rsp_dirty_high !== e.dirty_high) begin
               $error("dirty_high expected %0d actual %0d", e.dirty_high, rsp_dirty_high);
               fail_count++;
            end
            if (rsp_used_count !== e.used_count) begin
               $error("used_count expected %0d actual %0d", e.used_count, rsp_used_count);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run after a long stretch with no transfer on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_MAX) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

endmodule
